FILE: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: operation codes,
// controller states, datapath step codes, command and status structs.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RES_W       = 32;
  localparam int OUT_BITS    = 2 + 3 * RES_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FN_ADD,
    FN_SUB,
    FN_MUL,
    FN_DIV
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  // datapath micro-steps
  typedef enum logic [4:0] {
    ST_NX,   // nx = xw * xd + xn
    ST_NY,   // ny = yw * yd + yn
    ST_GD,   // g = gcd(xd, yd)
    ST_XQ,   // xq = xd / g
    ST_YQ,   // yq = yd / g
    ST_AX,   // mag = nx * yq
    ST_AY,   // rem = ny * xq
    ST_SUM,  // mag = signed combination of mag and rem
    ST_DA,   // den = yd * xq
    ST_MM,   // mag = nx * ny
    ST_MD,   // den = xd * yd
    ST_DM,   // mag = nx * yd
    ST_DD,   // den = ny * xd
    ST_RG,   // g = gcd(mag, den)
    ST_RM,   // mag = mag / g
    ST_RD,   // den = den / g
    ST_RQ    // mag, rem = mag / den, mag % den
  } step_t;

  typedef enum logic [1:0] {
    EM_MUL,
    EM_DIV,
    EM_GCD,
    EM_SUM
  } emode_t;

  typedef struct packed {
    logic  load;
    logic  start;
    step_t step;
    logic  emit;
    logic  zero;
  } cmd_t;

  typedef struct packed {
    logic  done;
    logic  zero;
    logic  out_busy;
    func_t func;
  } status_t;

endpackage

FILE: hdl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: accepts an item, walks the datapath through its micro-steps and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  rau_pkg::status_t status,
  output rau_pkg::cmd_t    cmd
);

  rau_pkg::state_t state, state_next;
  rau_pkg::step_t  step, step_next, step_seq;
  logic            zero_r, zero_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rau_pkg::S_IDLE;
      step   <= rau_pkg::ST_NX;
      zero_r <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      zero_r <= zero_next;
    end
  end

  always_comb begin
    step_seq = rau_pkg::ST_NX;
    unique case (step)
      rau_pkg::ST_NX: step_seq = rau_pkg::ST_NY;
      rau_pkg::ST_NY: begin
        unique case (status.func)
          rau_pkg::FN_MUL: step_seq = rau_pkg::ST_MM;
          rau_pkg::FN_DIV: step_seq = rau_pkg::ST_DM;
          default:         step_seq = rau_pkg::ST_GD;
        endcase
      end
      rau_pkg::ST_GD:  step_seq = rau_pkg::ST_XQ;
      rau_pkg::ST_XQ:  step_seq = rau_pkg::ST_YQ;
      rau_pkg::ST_YQ:  step_seq = rau_pkg::ST_AX;
      rau_pkg::ST_AX:  step_seq = rau_pkg::ST_AY;
      rau_pkg::ST_AY:  step_seq = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM: step_seq = rau_pkg::ST_DA;
      rau_pkg::ST_DA:  step_seq = rau_pkg::ST_RG;
      rau_pkg::ST_MM:  step_seq = rau_pkg::ST_MD;
      rau_pkg::ST_MD:  step_seq = rau_pkg::ST_RG;
      rau_pkg::ST_DM:  step_seq = rau_pkg::ST_DD;
      rau_pkg::ST_DD:  step_seq = rau_pkg::ST_RG;
      rau_pkg::ST_RG:  step_seq = rau_pkg::ST_RM;
      rau_pkg::ST_RM:  step_seq = rau_pkg::ST_RD;
      rau_pkg::ST_RD:  step_seq = rau_pkg::ST_RQ;
      default:         step_seq = rau_pkg::ST_NX;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    zero_next  = zero_r;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      rau_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = rau_pkg::ST_NX;
          zero_next  = 1'b0;
          state_next = rau_pkg::S_ISSUE;
        end
      end
      rau_pkg::S_ISSUE: begin
        // zero magnitude or divide by zero: skip the reduction
        if (step == rau_pkg::ST_RG && status.zero) begin
          zero_next  = 1'b1;
          state_next = rau_pkg::S_EMIT;
        end else begin
          cmd.start  = 1'b1;
          cmd.step   = step;
          state_next = rau_pkg::S_WAIT;
        end
      end
      rau_pkg::S_WAIT: begin
        if (status.done) begin
          if (step == rau_pkg::ST_RQ) begin
            state_next = rau_pkg::S_EMIT;
          end else begin
            step_next  = step_seq;
            state_next = rau_pkg::S_ISSUE;
          end
        end
      end
      rau_pkg::S_EMIT: begin
        cmd.zero = zero_r;
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = rau_pkg::S_IDLE;
        end
      end
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hdl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, one shared bit-serial engine (shift-add
// multiply, restoring divide, binary gcd) and the output register.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int P = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rau_pkg::cmd_t             cmd,
  output rau_pkg::status_t          status,
  input  logic [1:0]                func,
  input  logic                      x_neg,
  input  logic [P-1:0]              x_whole,
  input  logic [P-1:0]              x_num,
  input  logic [P-1:0]              x_den,
  input  logic                      y_neg,
  input  logic [P-1:0]              y_whole,
  input  logic [P-1:0]              y_num,
  input  logic [P-1:0]              y_den,
  input  logic                      m_tready,
  output logic                      out_valid,
  output logic                      r_neg,
  output logic [rau_pkg::RES_W-1:0] r_whole,
  output logic [rau_pkg::RES_W-1:0] r_num,
  output logic [rau_pkg::RES_W-1:0] r_den,
  output logic                      overflow
);

  localparam int N  = 2 * P + 1;
  localparam int W  = 4 * P + 2;
  localparam int CW = $clog2(W + 1);
  localparam int RW = rau_pkg::RES_W;

  typedef enum logic [1:0] {G_TWO, G_RED, G_BACK} gph_t;

  rau_pkg::func_t  func_r;
  logic            xs, ys, neg;
  logic [P-1:0]    xw, xn, xd, yw, yn, yd, xq, yq;
  logic [N-1:0]    nx, ny;
  logic [W-1:0]    g, mag, den, rem;

  rau_pkg::emode_t mode, sm;
  rau_pkg::step_t  wstep;
  gph_t            gph;
  logic            run, done;
  logic [W-1:0]    ea, eb, ec, ia, ib, ic;
  logic [CW-1:0]   ecnt, ek;

  logic            xs_e, ys_e, ysg, sum_neg, neg_f, ovf, bad;
  logic [W-1:0]    sum_mag;
  logic [W:0]      div_t, div_d;
  logic            div_ge;

  assign xs_e = xs & (nx != '0);
  assign ys_e = ys & (ny != '0);
  assign ysg  = ys_e ^ (func_r == rau_pkg::FN_SUB);

  always_comb begin
    if (xs_e == ysg) begin
      sum_mag = mag + rem;
      sum_neg = xs_e;
    end else if (mag >= rem) begin
      sum_mag = mag - rem;
      sum_neg = xs_e;
    end else begin
      sum_mag = rem - mag;
      sum_neg = ysg;
    end
  end

  assign div_t  = {ec, ea[W-1]};
  assign div_ge = div_t >= {1'b0, eb};
  assign div_d  = div_t - {1'b0, eb};

  // engine set-up per step
  always_comb begin
    sm = rau_pkg::EM_MUL;
    ia = '0;
    ib = '0;
    ic = '0;
    unique case (cmd.step)
      rau_pkg::ST_NX: begin ia = W'(xw); ib = W'(xd); ic = W'(xn); end
      rau_pkg::ST_NY: begin ia = W'(yw); ib = W'(yd); ic = W'(yn); end
      rau_pkg::ST_GD: begin sm = rau_pkg::EM_GCD; ia = W'(xd); ib = W'(yd); end
      rau_pkg::ST_XQ: begin sm = rau_pkg::EM_DIV; ia = W'(xd); ib = g; end
      rau_pkg::ST_YQ: begin sm = rau_pkg::EM_DIV; ia = W'(yd); ib = g; end
      rau_pkg::ST_AX: begin ia = W'(nx); ib = W'(yq); end
      rau_pkg::ST_AY: begin ia = W'(ny); ib = W'(xq); end
      rau_pkg::ST_SUM: sm = rau_pkg::EM_SUM;
      rau_pkg::ST_DA: begin ia = W'(yd); ib = W'(xq); end
      rau_pkg::ST_MM: begin ia = W'(nx); ib = W'(ny); end
      rau_pkg::ST_MD: begin ia = W'(xd); ib = W'(yd); end
      rau_pkg::ST_DM: begin ia = W'(nx); ib = W'(yd); end
      rau_pkg::ST_DD: begin ia = W'(ny); ib = W'(xd); end
      rau_pkg::ST_RG: begin sm = rau_pkg::EM_GCD; ia = mag; ib = den; end
      rau_pkg::ST_RM: begin sm = rau_pkg::EM_DIV; ia = mag; ib = g; end
      rau_pkg::ST_RD: begin sm = rau_pkg::EM_DIV; ia = den; ib = g; end
      rau_pkg::ST_RQ: begin sm = rau_pkg::EM_DIV; ia = mag; ib = den; end
      default: sm = rau_pkg::EM_SUM;
    endcase
  end

  // shared engine
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.start) begin
        mode  <= sm;
        wstep <= cmd.step;
        ea    <= ia;
        eb    <= ib;
        ec    <= ic;
        ecnt  <= '0;
        ek    <= '0;
        gph   <= G_TWO;
        run   <= (sm != rau_pkg::EM_SUM);
        done  <= (sm == rau_pkg::EM_SUM);
      end else if (run) begin
        unique case (mode)
          rau_pkg::EM_MUL: begin
            if (eb == '0) begin
              run  <= 1'b0;
              done <= 1'b1;
            end else begin
              done <= 1'b0;
              if (eb[0]) ec <= ec + ea;
              ea <= ea << 1;
              eb <= eb >> 1;
            end
          end
          rau_pkg::EM_DIV: begin
            ec   <= div_ge ? div_d[W-1:0] : div_t[W-1:0];
            ea   <= {ea[W-2:0], div_ge};
            ecnt <= ecnt + 1'b1;
            if (ecnt == CW'(W - 1)) begin
              run  <= 1'b0;
              done <= 1'b1;
            end else begin
              done <= 1'b0;
            end
          end
          rau_pkg::EM_GCD: begin
            unique case (gph)
              G_TWO: begin
                done <= 1'b0;
                if (!ea[0] && !eb[0]) begin
                  ea <= ea >> 1;
                  eb <= eb >> 1;
                  ek <= ek + 1'b1;
                end else begin
                  gph <= G_RED;
                end
              end
              G_RED: begin
                done <= 1'b0;
                priority if (ea == '0) gph <= G_BACK;
                else if (!ea[0])       ea <= ea >> 1;
                else if (!eb[0])       eb <= eb >> 1;
                else if (ea >= eb)     ea <= ea - eb;
                else                   eb <= eb - ea;
              end
              default: begin
                if (ek == '0) begin
                  run  <= 1'b0;
                  done <= 1'b1;
                end else begin
                  done <= 1'b0;
                  eb <= eb << 1;
                  ek <= ek - 1'b1;
                end
              end
            endcase
          end
          default: begin
            run  <= 1'b0;
            done <= 1'b0;
          end
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

  // operand capture and write-back
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= rau_pkg::func_t'(func);
      xs     <= x_neg;
      ys     <= y_neg;
      xd     <= (x_den == '0) ? P'(1) : x_den;
      xw     <= (x_den == '0) ? '0 : x_whole;
      xn     <= (x_den == '0) ? '0 : x_num;
      yd     <= (y_den == '0) ? P'(1) : y_den;
      yw     <= (y_den == '0) ? '0 : y_whole;
      yn     <= (y_den == '0) ? '0 : y_num;
    end
    if (done) begin
      unique case (wstep)
        rau_pkg::ST_NX:  nx  <= ec[N-1:0];
        rau_pkg::ST_NY:  ny  <= ec[N-1:0];
        rau_pkg::ST_GD:  g   <= eb;
        rau_pkg::ST_XQ:  xq  <= ea[P-1:0];
        rau_pkg::ST_YQ:  yq  <= ea[P-1:0];
        rau_pkg::ST_AX:  mag <= ec;
        rau_pkg::ST_AY:  rem <= ec;
        rau_pkg::ST_SUM: begin
          mag <= sum_mag;
          neg <= sum_neg;
        end
        rau_pkg::ST_DA:  den <= ec;
        rau_pkg::ST_MM:  mag <= ec;
        rau_pkg::ST_MD:  den <= ec;
        rau_pkg::ST_DM:  mag <= ec;
        rau_pkg::ST_DD:  den <= ec;
        rau_pkg::ST_RG:  g   <= eb;
        rau_pkg::ST_RM:  mag <= ea;
        rau_pkg::ST_RD:  den <= ea;
        rau_pkg::ST_RQ: begin
          mag <= ea;
          rem <= ec;
        end
        default: ;
      endcase
    end
  end

  assign neg_f = (func_r == rau_pkg::FN_ADD || func_r == rau_pkg::FN_SUB) ? neg
                                                                        : (xs_e ^ ys_e);
  assign ovf   = (mag[W-1:RW] != '0) || (den[W-1:RW] != '0);
  assign bad   = cmd.zero || ovf;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      r_neg    <= bad ? 1'b0 : neg_f;
      r_whole  <= bad ? '0 : mag[RW-1:0];
      r_num    <= bad ? '0 : rem[RW-1:0];
      r_den    <= bad ? RW'(1) : den[RW-1:0];
      overflow <= !cmd.zero && ovf;
    end
  end

  assign status.done     = done;
  assign status.zero     = (mag == '0) || (den == '0);
  assign status.out_busy = out_valid & ~m_tready;
  assign status.func     = func_r;

endmodule

FILE: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply and divide of signed mixed fractions, result
// reduced to lowest terms and returned as sign, whole part and proper fraction.
// ----------------------------------------------------------------------------
// One item is worked at a time through a single bit-serial engine, which
// does one shift-add per multiplier bit in a multiply, one restoring step per
// quotient bit in a divide and one shift or subtract per cycle in a gcd. Add
// and subtract take two gcds, five divides and five multiplies; multiply and
// divide take fewer steps. A new item is taken as soon as the previous result
// sits in the output register.
module rational_arithmetic_unit #(
  parameter int PART_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // func, x_neg, x_whole, x_num, x_den, y_neg, y_whole, y_num, y_den
  input  logic [((4+6*PART_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // r_neg, r_whole, r_num, r_den, overflow
  output logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int P   = PART_WIDTH;
  localparam int RW  = rau_pkg::RES_W;
  localparam int PAD = rau_pkg::OUT_TDATA_W - rau_pkg::OUT_BITS;

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;
  logic             r_neg, overflow;
  logic [RW-1:0]    r_whole, r_num, r_den;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rau_dp #(.P(P)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .func      (s_tdata[1:0]),
    .x_neg     (s_tdata[2]),
    .x_whole   (s_tdata[3 +: P]),
    .x_num     (s_tdata[3+P +: P]),
    .x_den     (s_tdata[3+2*P +: P]),
    .y_neg     (s_tdata[3+3*P]),
    .y_whole   (s_tdata[4+3*P +: P]),
    .y_num     (s_tdata[4+4*P +: P]),
    .y_den     (s_tdata[4+5*P +: P]),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .r_neg     (r_neg),
    .r_whole   (r_whole),
    .r_num     (r_num),
    .r_den     (r_den),
    .overflow  (overflow)
  );

  assign m_tdata = {{PAD{1'b0}}, overflow, r_den, r_num, r_whole, r_neg};

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_den != '0)
    else $error("zero result denominator");

  a_proper: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !overflow |-> r_num < r_den)
    else $error("result fraction not proper");

  a_ovf_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && overflow |-> r_whole == '0 && r_num == '0 && !r_neg && r_den == RW'(1))
    else $error("overflow result not cleared");

endmodule
